[rtl/safc_pkg.sv]
// ----------------------------------------------------------------------------
// safc_pkg
// Shared widths, register indexes and codes of the set-associative cache tag
// store with FIFO replacement and memory-traffic counters.
// ----------------------------------------------------------------------------
package safc_pkg;

    // Address and counter widths
    localparam int ADDR_BITS  = 48;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd2;
    localparam logic [CFG_DATA_W-1:0] SET_BITS_RST    = 4'd0;
    localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RST = 4'd1;

    // Access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

endpackage

[rtl/safc_req_if.sv]
// ----------------------------------------------------------------------------
// safc_req_if
// Access request channel: kind and byte address, valid/ready handshake.
// ----------------------------------------------------------------------------
interface safc_req_if import safc_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);

endinterface

[rtl/safc_rsp_if.sv]
// ----------------------------------------------------------------------------
// safc_rsp_if
// Result channel: hit flag and running traffic and hit/miss counts.
// ----------------------------------------------------------------------------
interface safc_rsp_if import safc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             hit;
    logic [CNT_W-1:0] mem_reads;
    logic [CNT_W-1:0] mem_writes;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;

    modport source (
        output valid, output hit, output mem_reads, output mem_writes,
        output hit_count, output miss_count, input ready
    );
    modport sink (
        input valid, input hit, input mem_reads, input mem_writes,
        input hit_count, input miss_count, output ready
    );

endinterface

[rtl/safc_cfg_if.sv]
// ----------------------------------------------------------------------------
// safc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface safc_cfg_if import safc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

[rtl/safc_ram.sv]
// ----------------------------------------------------------------------------
// safc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module safc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/set_assoc_cache_fifo_counter_unit.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_counter_unit
// Tag store of a set-associative cache with FIFO replacement and counters.
// ----------------------------------------------------------------------------
// A request is handled in a read step and a compare step: in the first the
// set's row (all way tags, valid bits and the set's FIFO pointer) is read from
// the row RAM, in the second the ways are compared, the row is written back on
// a miss and the result is loaded into the output register. The single row
// RAM port pair sets this split. A new request is taken while a finished
// result still waits on the result channel; the compare step stretches only
// while that earlier result has not been taken. After reset a clearing pass
// writes every row to invalid, one row a cycle; no request is accepted during
// that pass, configuration writes are.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_counter_unit import safc_pkg::*; #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    safc_req_if.sink    req,
    safc_rsp_if.source  rsp,
    safc_cfg_if.sink    cfg
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
    localparam int PTR_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W   = $clog2(MAX_WAYS + 1);
    localparam int TAGS_W  = MAX_WAYS * ADDR_BITS;
    localparam int ROW_W   = TAGS_W + MAX_WAYS + PTR_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;

    logic [CFG_DATA_W-1:0] offset_bits_reg;
    logic [CFG_DATA_W-1:0] set_bits_reg;
    logic [CFG_DATA_W-1:0] ways_reg;

    logic [SET_W-1:0]     clr_idx_reg;
    logic                 kind_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [SET_W-1:0]     set_reg;

    logic             rsp_valid_reg;
    logic             hit_reg;
    logic [CNT_W-1:0] reads_reg;
    logic [CNT_W-1:0] writes_reg;
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] misses_reg;

    logic                 req_fire;
    logic [4:0]           sb_eff;
    logic [5:0]           shift;
    logic [ADDR_BITS-1:0] tag_in;
    logic [ADDR_BITS-1:0] set_full;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_in;

    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_next;
    logic [WAY_W-1:0] ways_eff;
    logic [PTR_W-1:0] ptr_old;
    logic [PTR_W-1:0] fill_way;
    logic [PTR_W-1:0] ptr_next;
    logic             hit_any;
    logic             done;

    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    // Configuration registers, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            set_bits_reg    <= SET_BITS_RST;
            ways_reg        <= WAYS_IN_USE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg.data;
                CFG_SET_BITS:    set_bits_reg    <= cfg.data;
                CFG_WAYS_IN_USE: ways_reg        <= cfg.data;
                default: ;
            endcase
        end
    end

    // Split the address into set index and tag
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        if ({1'b0, set_bits_reg} > 5'(SET_LIM))
        begin
            sb_eff = 5'(SET_LIM);
        end
        else
        begin
            sb_eff = {1'b0, set_bits_reg};
        end
        shift    = {2'b00, offset_bits_reg} + {1'b0, sb_eff};
        tag_in   = req.address >> shift;
        set_full = req.address >> offset_bits_reg;
        set_mask = SET_W'((32'd1 << sb_eff) - 32'd1);
        set_in   = set_full[SET_W-1:0] & set_mask;
    end

    // Clamp the ways in use and compare the stored tags of the set
    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_eff = WAY_W'(1);
        end
        else if (32'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAY_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAY_W'(ways_reg);
        end

        hit_any = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if ((WAY_W'(w) < ways_eff) && row_rd[TAGS_W + w]
                && (row_rd[w*ADDR_BITS +: ADDR_BITS] == tag_reg))
            begin
                hit_any = 1'b1;
            end
        end
    end

    // Pick the FIFO victim and build the row to write back
    always_comb
    begin
        ptr_old = row_rd[ROW_W-1 -: PTR_W];
        if (32'(ptr_old) >= 32'(ways_eff))
        begin
            fill_way = '0;
        end
        else
        begin
            fill_way = ptr_old;
        end
        if ((32'(fill_way) + 32'd1) == 32'(ways_eff))
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = fill_way + PTR_W'(1);
        end

        row_next = row_rd;
        row_next[int'(fill_way)*ADDR_BITS +: ADDR_BITS] = tag_reg;
        row_next[TAGS_W + int'(fill_way)]               = 1'b1;
        row_next[ROW_W-1 -: PTR_W]                      = ptr_next;
    end

    // Finish the lookup once the output register is free
    assign done = (state_reg == ST_LOOKUP) && (!rsp_valid_reg || rsp.ready);

    // RAM write: clearing pass or fill on a miss
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = done && !hit_any;
            ram_waddr = set_reg;
            ram_wdata = row_next;
        end
    end

    safc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req_fire),
        .raddr (set_in),
        .rdata (row_rd)
    );

    // Sequencer, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            reads_reg     <= '0;
            writes_reg    <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + SET_W'(1);
                    if (clr_idx_reg == SET_W'(MAX_SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (done)
            begin
                if (hit_any)
                begin
                    hits_reg <= sat_inc(hits_reg);
                end
                else
                begin
                    misses_reg <= sat_inc(misses_reg);
                    reads_reg  <= sat_inc(reads_reg);
                end
                if (kind_reg == KIND_WRITE)
                begin
                    writes_reg <= sat_inc(writes_reg);
                end
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            tag_reg  <= tag_in;
            set_reg  <= set_in;
        end
        if (done)
        begin
            hit_reg <= hit_any;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.mem_reads  = reads_reg;
    assign rsp.mem_writes = writes_reg;
    assign rsp.hit_count  = hits_reg;
    assign rsp.miss_count = misses_reg;

endmodule

[rtl/safc_checker.sv]
// ----------------------------------------------------------------------------
// safc_props
// Port-level checks of the cache tag store: result ordering and counting.
// ----------------------------------------------------------------------------
module safc_props import safc_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_hit,
    input logic [CNT_W-1:0] rsp_mem_reads,
    input logic [CNT_W-1:0] rsp_mem_writes,
    input logic [CNT_W-1:0] rsp_hit_count,
    input logic [CNT_W-1:0] rsp_miss_count
);

    logic             req_fire;
    logic             rsp_fire;
    logic [1:0]       pend_reg;
    logic             have_last_reg;
    logic [CNT_W-1:0] last_reads_reg;
    logic [CNT_W-1:0] last_writes_reg;
    logic [CNT_W-1:0] last_hits_reg;
    logic [CNT_W-1:0] last_misses_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Track requests in flight and the last result taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            have_last_reg <= 1'b0;
        end
        else
        begin
            if (req_fire && !rsp_fire && (pend_reg != 2'd3))
            begin
                pend_reg <= pend_reg + 2'd1;
            end
            else if (rsp_fire && !req_fire && (pend_reg != 2'd0))
            begin
                pend_reg <= pend_reg - 2'd1;
            end
            if (rsp_fire)
            begin
                have_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_fire)
        begin
            last_reads_reg  <= rsp_mem_reads;
            last_writes_reg <= rsp_mem_writes;
            last_hits_reg   <= rsp_hit_count;
            last_misses_reg <= rsp_miss_count;
        end
    end

    // A held result keeps its hit flag and its hit and miss totals
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
            && $stable(rsp_hit_count) && $stable(rsp_miss_count))
        else $error("result changed while stalled");

    // No result without a request in flight
    a_rsp_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pend_reg != 2'd0))
        else $error("result shown with no request in flight");

    // Exactly one of hit and miss totals advances per result
    a_hit_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && have_last_reg && (last_hits_reg != CNT_MAX)
            && (last_misses_reg != CNT_MAX)
        |-> (rsp_hit ? ((rsp_hit_count == last_hits_reg + CNT_W'(1))
                        && (rsp_miss_count == last_misses_reg))
                     : ((rsp_miss_count == last_misses_reg + CNT_W'(1))
                        && (rsp_hit_count == last_hits_reg))))
        else $error("hit or miss total stepped wrongly");

    // A hit causes no memory read
    a_hit_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && have_last_reg && rsp_hit |-> (rsp_mem_reads == last_reads_reg))
        else $error("memory read counted on a hit");

    // The memory write total advances by at most one per result
    a_write_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && have_last_reg && (last_writes_reg != CNT_MAX)
        |-> ((rsp_mem_writes == last_writes_reg)
             || (rsp_mem_writes == last_writes_reg + CNT_W'(1))))
        else $error("memory write total stepped wrongly");

endmodule

bind set_assoc_cache_fifo_counter_unit safc_props u_safc_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_mem_reads  (rsp.mem_reads),
    .rsp_mem_writes (rsp.mem_writes),
    .rsp_hit_count  (rsp.hit_count),
    .rsp_miss_count (rsp.miss_count)
);
